FILE: src/rcf_pkg.sv
// Package for the rational continued fraction core.
// Shared widths, term limit default and sequencer state type.
// No dependencies.
package rcf_pkg;

    localparam int DATA_W            = 64;
    localparam int MAX_TERMS_DEFAULT = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT
    } rcf_state_t;

endpackage

FILE: src/rcf_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses rcf_pkg for the data width.
module rcf_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rcf_pkg::DATA_W-1:0] dividend,
    input  logic [rcf_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [rcf_pkg::DATA_W-1:0] quotient,
    output logic [rcf_pkg::DATA_W-1:0] remainder
);
    import rcf_pkg::*;

    localparam int CntW = $clog2(DATA_W);

    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // borrow clear means the shifted remainder covers the divisor
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(DATA_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: src/rational_continued_fraction_core.sv
// Continued fraction expansion of a signed rational, one coefficient per strobe.
// Each coefficient costs one pass of the shared divider.
// A transaction with k coefficients keeps busy high while they are computed, k <= MAX_TERMS.
// Results are registered and shown for one cycle on strobe; the receiver cannot stall.
// Reset (rst_n low, asynchronous) returns the sequencer to idle; no results pending.
// Depends on rcf_pkg and rcf_div.
module rational_continued_fraction_core #(
    parameter int MAX_TERMS = rcf_pkg::MAX_TERMS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [rcf_pkg::DATA_W-1:0] numerator,
    input  logic [rcf_pkg::DATA_W-1:0] denominator,
    input  logic                       negative,
    output logic                       strobe,
    output logic [rcf_pkg::DATA_W-1:0] coefficient,
    output logic                       coefficient_negative,
    output logic                       last,
    output logic                       truncated
);
    import rcf_pkg::*;

    localparam int CntW = $clog2(MAX_TERMS + 1);

    rcf_state_t        state_reg, state_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic              neg_reg, neg_next;
    logic              first_reg, first_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              strobe_reg, strobe_next;
    logic [DATA_W-1:0] coef_reg, coef_next;
    logic              cneg_reg, cneg_next;
    logic              last_reg, last_next;
    logic              trunc_reg, trunc_next;

    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic [DATA_W-1:0] div_rem;
    logic              rem_zero;
    logic              at_limit;

    rcf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign rem_zero = (div_rem == '0);
    assign at_limit = ((count_reg + 1'b1) == CntW'(MAX_TERMS));

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        neg_next    = neg_reg;
        first_next  = first_reg;
        count_next  = count_reg;
        strobe_next = 1'b0;
        coef_next   = coef_reg;
        cneg_next   = cneg_reg;
        last_next   = last_reg;
        trunc_next  = trunc_reg;
        div_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next     = numerator;
                    // zero denominator behaves as one
                    b_next     = (denominator == '0) ? DATA_W'(1) : denominator;
                    neg_next   = negative;
                    first_next = 1'b1;
                    count_next = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    strobe_next = 1'b1;
                    first_next  = 1'b0;
                    count_next  = count_reg + 1'b1;
                    a_next      = b_reg;
                    if (first_reg && neg_reg && !rem_zero)
                    begin
                        // floor of a negative non-integer: bump magnitude, flip fraction
                        coef_next = div_quo + 1'b1;
                        cneg_next = 1'b1;
                        b_next    = b_reg - div_rem;
                    end
                    else
                    begin
                        coef_next = div_quo;
                        cneg_next = first_reg && neg_reg && (div_quo != '0);
                        b_next    = div_rem;
                    end
                    // the flipped fraction is nonzero exactly when the remainder is
                    last_next  = rem_zero || at_limit;
                    trunc_next = at_limit && !rem_zero;
                    state_next = (rem_zero || at_limit) ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            first_reg  <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            first_reg  <= first_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        neg_reg   <= neg_next;
        coef_reg  <= coef_next;
        cneg_reg  <= cneg_next;
        last_reg  <= last_next;
        trunc_reg <= trunc_next;
    end

    assign busy                 = (state_reg != ST_IDLE);
    assign strobe               = strobe_reg;
    assign coefficient          = coef_reg;
    assign coefficient_negative = cneg_reg;
    assign last                 = last_reg;
    assign truncated            = trunc_reg;

    // a non-final coefficient always leaves another divide pass in flight
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |-> busy)
        else $error("sequencer idle after a non-final coefficient");

    // the final coefficient ends the transaction
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> !busy)
        else $error("sequencer still busy after the final coefficient");

    // a negative coefficient can only be the first of a transaction
    a_neg_first: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && cneg_reg) |-> (count_reg == CntW'(1)))
        else $error("negative coefficient past the first term");

    // truncation is only ever flagged at the term limit
    a_trunc_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && trunc_reg) |-> (last_reg && count_reg == CntW'(MAX_TERMS)))
        else $error("truncated flag away from the term limit");

endmodule
